@@ hdl/bfa_pkg.sv @@
// shared constants and command/status types for the bitmap fit allocator
package bfa_pkg;
  localparam int NumUnits = 256;
  localparam int UnitW = 8;
  localparam int LenW = 17;

  localparam logic [1:0] PolicyFirst = 2'd0;
  localparam logic [1:0] PolicyNext = 2'd1;
  localparam logic [1:0] PolicyBest = 2'd2;
  localparam logic [1:0] PolicyWorst = 2'd3;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree = 1'b1;

  localparam logic RegFitPolicy = 1'b0;
  localparam logic RegUnitShift = 1'b1;

  localparam logic [3:0] UnitShiftReset = 4'd4;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic mark_step;
  } bfa_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_free;
    logic bad_len;
    logic scan_done;
    logic mark_done;
    logic found;
  } bfa_status_t;
endpackage

@@ hdl/bfa_ctrl.sv @@
// controller state machine for the bitmap fit allocator
module bfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bfa_pkg::bfa_cmd_t   cmd,
  input  bfa_pkg::bfa_status_t status
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDecide = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StMark = 3'd3;
  localparam logic [2:0] StOut = 3'd4;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= StIdle;
    else state <= state_next;
  end

  // no item is taken while the bitmap is still being cleared
  assign in_ready = (state == StIdle) && status.clear_done;
  assign out_valid = (state == StOut);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      StIdle: begin
        if (in_valid && status.clear_done) begin
          cmd.load = 1'b1;
          state_next = StDecide;
        end
      end
      StDecide: begin
        if (status.is_free) state_next = StMark;
        else if (status.bad_len) state_next = StOut;
        else state_next = StScan;
      end
      StScan: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          if (status.found) state_next = StMark;
          else state_next = StOut;
        end
      end
      StMark: begin
        cmd.mark_step = 1'b1;
        if (status.mark_done) state_next = StOut;
      end
      StOut: begin
        if (out_ready) state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end
endmodule

@@ hdl/bfa_datapath.sv @@
// bitmap, run scanner and marking logic for the bitmap fit allocator
module bfa_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  bfa_pkg::bfa_cmd_t    cmd,
  output bfa_pkg::bfa_status_t status,
  input  logic [1:0]           fit_policy,
  input  logic [3:0]           unit_shift,
  input  logic                 op,
  input  logic [15:0]          request_size,
  input  logic [7:0]           free_start,
  output logic                 ok,
  output logic [7:0]           alloc_start
);
  localparam int N = bfa_pkg::NumUnits;
  localparam int UW = bfa_pkg::UnitW;
  localparam int LW = bfa_pkg::LenW;
  localparam int CW = UW + 1;

  logic used_mem [N];
  logic rd_bit;
  logic [UW-1:0] roving;

  logic is_free;
  logic [1:0] policy;
  logic [LW-1:0] len;
  logic [UW-1:0] base;
  logic [CW-1:0] pos;
  logic [CW-1:0] run_len;
  logic [UW-1:0] run_head;
  logic found;
  logic [UW-1:0] pick;
  logic [CW-1:0] pick_size;
  logic [CW-1:0] mark_pos;
  logic [CW-1:0] mark_end;
  logic [CW-1:0] clr_pos;

  logic [LW-1:0] len_calc;
  logic [16:0] sum_calc;
  always_comb begin
    sum_calc = {1'b0, request_size} + ((17'd1 << unit_shift) - 17'd1);
    len_calc = sum_calc >> unit_shift;
  end

  // unit under scan: next fit walks from the roving pointer and wraps
  logic [UW-1:0] cur;
  logic cur_used;
  logic at_end;
  logic [CW-1:0] scan_last;
  logic [CW-1:0] pos_inc;
  logic [CW-1:0] run_len_inc;
  logic run_ok;
  assign cur = (policy == bfa_pkg::PolicyNext) ? base + pos[UW-1:0] : pos[UW-1:0];
  // the bit of cur comes from the registered read issued on load or on the previous scan step
  assign cur_used = rd_bit;
  // next fit goes on past the roving pointer so a run may start just below it
  assign scan_last = (policy == bfa_pkg::PolicyNext) ? CW'(N - 2) + len[CW-1:0]
                                                     : CW'(N - 1);
  assign at_end = (pos == scan_last);
  assign pos_inc = pos + CW'(1);
  // next fit: a run restarts on wrap to unit zero
  logic wrap_restart;
  assign wrap_restart = (policy == bfa_pkg::PolicyNext) && (cur == '0);
  assign run_len_inc = (wrap_restart ? CW'(0) : run_len) + CW'(1);
  assign run_ok = ({{(LW-CW){1'b0}}, run_len_inc} >= len);

  logic [UW-1:0] head_now;
  assign head_now = (wrap_restart || run_len == '0) ? cur : run_head;

  // best/worst evaluate a finished maximal run
  logic end_run;
  logic [CW-1:0] fin_size;
  logic [UW-1:0] fin_head;
  logic fin_take;
  always_comb begin
    end_run = 1'b0;
    fin_size = run_len;
    fin_head = run_head;
    if (cur_used) end_run = (run_len != '0);
    else if (at_end) begin
      end_run = 1'b1;
      fin_size = run_len_inc;
      fin_head = head_now;
    end
    fin_take = end_run && ({{(LW-CW){1'b0}}, fin_size} >= len) &&
               (!found || ((policy == bfa_pkg::PolicyWorst) ? fin_size > pick_size
                                                            : fin_size < pick_size));
  end

  logic first_hit;
  assign first_hit = !cur_used && run_ok &&
                     (policy == bfa_pkg::PolicyFirst || policy == bfa_pkg::PolicyNext);

  // bitmap port: one read and one write a cycle
  logic clearing;
  logic mem_re;
  logic [UW-1:0] mem_raddr;
  logic mem_we;
  logic [UW-1:0] mem_waddr;
  logic mem_wdata;
  assign clearing = !clr_pos[UW];
  assign mem_re = cmd.load || cmd.scan_step;
  assign mem_raddr = cmd.load ? ((fit_policy == bfa_pkg::PolicyNext) ? roving : '0)
                   : ((policy == bfa_pkg::PolicyNext) ? base + pos_inc[UW-1:0]
                                                      : pos_inc[UW-1:0]);
  assign mem_we = clearing || (cmd.mark_step && !status.mark_done);
  assign mem_waddr = clearing ? clr_pos[UW-1:0] : mark_pos[UW-1:0];
  assign mem_wdata = clearing ? 1'b0 : !is_free;

  always_comb begin
    status.clear_done = !clearing;
    status.is_free = is_free;
    status.bad_len = (len == '0) || (len > LW'(N));
    status.found = found || first_hit || fin_take;
    status.scan_done = first_hit || at_end;
    status.mark_done = (mark_pos >= mark_end);
  end

  // clearing pass after reset, one unit per cycle
  always_ff @(posedge clk) begin
    if (rst) clr_pos <= '0;
    else if (clearing) clr_pos <= clr_pos + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) used_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_bit <= used_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roving <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.load) begin
        is_free <= op;
        policy <= fit_policy;
        len <= len_calc;
        base <= roving;
        pos <= '0;
        run_len <= '0;
        found <= 1'b0;
        pick_size <= '0;
        pick <= '0;
        ok <= op;
        alloc_start <= '0;
        mark_pos <= {1'b0, free_start};
        if (len_calc >= LW'(N) - LW'(free_start)) mark_end <= CW'(N);
        else mark_end <= CW'({1'b0, free_start}) + len_calc[CW-1:0];
      end
      if (cmd.scan_step) begin
        pos <= pos_inc;
        if (cur_used) run_len <= '0;
        else begin
          run_len <= run_len_inc;
          run_head <= head_now;
        end
        if (first_hit) begin
          found <= 1'b1;
          pick <= head_now;
        end else if (fin_take) begin
          found <= 1'b1;
          pick <= fin_head;
          pick_size <= fin_size;
        end
        if (status.scan_done && status.found) begin
          mark_pos <= {1'b0, first_hit ? head_now : (fin_take ? fin_head : pick)};
          mark_end <= CW'({1'b0, first_hit ? head_now : (fin_take ? fin_head : pick)})
                      + len[CW-1:0];
          ok <= 1'b1;
          alloc_start <= first_hit ? head_now : (fin_take ? fin_head : pick);
          if (policy == bfa_pkg::PolicyNext) roving <= head_now;
        end
      end
      if (cmd.mark_step && !status.mark_done) mark_pos <= mark_pos + CW'(1);
    end
  end
endmodule

@@ hdl/bitmap_fit_allocator_unit.sv @@
// top level of the bitmap fit allocator
// channel  | handshake              | payload
// in       | in_valid / in_ready    | op, request_size, free_start
// out      | out_valid / out_ready  | ok, alloc_start
// cfg      | cfg_we                 | cfg_index, cfg_data
// an item is accepted, then decoded; an allocate of a valid length then walks the
// bitmap one unit per cycle, up to 256 units, next fit up to 255 plus the length
// as it comes round past the roving pointer; the run is then marked unit by unit,
// and a free marks its clipped run the same way
// reset clears the roving pointer; a clearing pass then frees every unit, in_ready low
// the result holds in an output register until taken; no new item meanwhile
module bitmap_fit_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [15:0] request_size,
  input  logic [7:0]  free_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [7:0]  alloc_start,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);
  logic [1:0] fit_policy;
  logic [3:0] unit_shift;
  bfa_pkg::bfa_cmd_t cmd;
  bfa_pkg::bfa_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= bfa_pkg::PolicyFirst;
      unit_shift <= bfa_pkg::UnitShiftReset;
    end else if (cfg_we) begin
      if (cfg_index == bfa_pkg::RegFitPolicy) fit_policy <= cfg_data[1:0];
      else unit_shift <= cfg_data;
    end
  end

  bfa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
  );

  bfa_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .fit_policy(fit_policy), .unit_shift(unit_shift),
    .op(op), .request_size(request_size), .free_start(free_start),
    .ok(ok), .alloc_start(alloc_start)
  );
endmodule
